### rtl/core/dst_pkg.sv
package dst_pkg;

  localparam int DATA_W      = 64;
  localparam int ID_W        = 16;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int NUM_IDS_DEF = 16;
  localparam int WINDOW_DEF  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_RESTART = 2'd0,
    OP_POST    = 2'd1,
    OP_WAIT    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_READY        = 3'd1,
    ST_NOT_READY    = 3'd2,
    ST_ID_ERROR     = 3'd3,
    ST_POST_IGNORED = 3'd4
  } status_t;

endpackage

### rtl/core/dst_if.sv
interface dst_req_if import dst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] iteration;
  logic signed [DATA_W-1:0] distance;
  logic [ID_W-1:0]          dep_id;

  modport source (output valid, opcode, iteration, distance, dep_id, input ready);
  modport sink   (input valid, opcode, iteration, distance, dep_id, output ready);
endinterface

interface dst_rsp_if import dst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

interface dst_cfg_if import dst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/doacross_sync_table.sv
// DOACROSS post/wait table. One request yields one status response.
// A request is taken only in the idle state, so the next one waits until
// the last has passed to its response. A wait also passes the table read
// state, which a post skips; with a WINDOW that is not a power of two the
// slot remainder unit works a byte at a time. An id error, a wait
// before loop_start or opcode 3 answers sooner. A response not yet taken
// holds the next one back. Restart clears all NUM_IDS*WINDOW entries, one
// entry per cycle, before it answers. After reset the same clearing pass
// runs and no request is taken until it ends; loop_start writes are taken
// at any time.
module doacross_sync_table import dst_pkg::*; #(
  parameter int NUM_IDS = NUM_IDS_DEF,
  parameter int WINDOW  = WINDOW_DEF
) (
  input  logic     clk,
  input  logic     rst,
  dst_req_if.sink  req,
  dst_rsp_if.source rsp,
  dst_cfg_if.sink  cfg
);

  localparam int DEPTH   = NUM_IDS * WINDOW;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(WINDOW);
  localparam int ENTRY_W = DATA_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_KEY, S_SLOT, S_ACCESS, S_READ, S_DONE
  } state_t;

  state_t                   state;
  opcode_t                  op;
  logic signed [DATA_W-1:0] iter;
  logic signed [DATA_W-1:0] distance;
  logic [ID_W-1:0]          id;
  logic signed [DATA_W-1:0] key;
  logic                     id_ok;
  logic signed [DATA_W-1:0] loop_start;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            clr_addr;
  logic                     restart;
  status_t                  status;

  logic                     before_start;
  logic                     slot_start;
  logic                     slot_done;
  logic [SW-1:0]            slot;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic                     hit;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_start <= '0;
    end else if (cfg.valid) begin
      loop_start <= cfg.data;
    end
  end

  always_comb begin
    before_start = key < loop_start;
    slot_start   = (state == S_KEY) && id_ok && !((op == OP_WAIT) && before_start);
    ram_we       = (state == S_CLEAR) || ((state == S_ACCESS) && (op == OP_POST));
    ram_addr     = (state == S_CLEAR) ? clr_addr : addr;
    // clearing writes a zero valid bit; the value field is don't-care
    ram_wdata    = (state == S_CLEAR) ? '0 : {1'b1, key};
    hit          = ram_rdata[DATA_W] && ($signed(ram_rdata[DATA_W-1:0]) >= key);
  end

  dst_slot_unit #(
    .WINDOW (WINDOW)
  ) u_slot (
    .clk   (clk),
    .rst   (rst),
    .start (slot_start),
    .value (key),
    .done  (slot_done),
    .slot  (slot)
  );

  dst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      restart    <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            if (restart) begin
              status <= ST_ACCEPTED;
              state  <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op       <= opcode_t'(req.opcode);
            iter     <= req.iteration;
            distance <= req.distance;
            id       <= req.dep_id;
            if (opcode_t'(req.opcode) == OP_RESTART) begin
              restart  <= 1'b1;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          key   <= (op == OP_WAIT) ? iter - distance : iter;
          id_ok <= id < ID_W'(NUM_IDS);
          if (op == OP_POST || op == OP_WAIT) begin
            state <= S_KEY;
          end else begin
            status <= ST_ACCEPTED;
            state  <= S_DONE;
          end
        end
        S_KEY: begin
          if (!id_ok) begin
            status <= (op == OP_POST) ? ST_POST_IGNORED : ST_ID_ERROR;
            state  <= S_DONE;
          end else if ((op == OP_WAIT) && before_start) begin
            status <= ST_READY;
            state  <= S_DONE;
          end else begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (slot_done) begin
            addr  <= AW'(AW'(id) * AW'(WINDOW) + AW'(slot));
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (op == OP_POST) begin
            status <= ST_ACCEPTED;
            state  <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          status <= hit ? ST_READY : ST_NOT_READY;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid  <= 1'b1;
            rsp.status <= status;
            restart    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/dst_ram.sv
module dst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/dst_slot_unit.sv
// Floor modulo of a signed 64-bit value by WINDOW.
// Power-of-two window: low bits, done in the cycle after start.
// Otherwise: the unsigned view is folded in a byte at a time, each byte
// a reciprocal multiply for the quotient and then a subtract, then a
// fix-up for negative values before done is raised.
module dst_slot_unit import dst_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DATA_W-1:0]         value,
  output logic                      done,
  output logic [$clog2(WINDOW)-1:0] slot
);

  localparam int  SW   = $clog2(WINDOW);
  localparam bit  POW2 = (WINDOW & (WINDOW - 1)) == 0;

  generate
    if (POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          slot <= value[SW-1:0];
        end
      end
    end else begin : g_serial
      localparam int            CHUNK   = 8;
      localparam int            NCHUNK  = DATA_W / CHUNK;
      localparam int            CNT_W   = $clog2(NCHUNK + 1);
      localparam int            XW      = SW + CHUNK;
      localparam logic [63:0]   WIN64   = 64'(WINDOW);
      localparam logic [63:0]   TOP_REM = 64'hFFFF_FFFF_FFFF_FFFF % WIN64;
      // 2^64 mod WINDOW: what the unsigned view adds to a negative value
      localparam logic [SW:0]   WRAP    = (SW+1)'((TOP_REM + 64'd1) % WIN64);
      localparam logic [SW:0]   W_EXT   = (SW+1)'(WINDOW);
      // ceil(2^32 / WINDOW): exact quotient for any x below WINDOW * 2^8
      localparam logic [31:0]   RECIP   = 32'((64'h1_0000_0000 + WIN64 - 64'd1) / WIN64);
      localparam logic [XW-1:0] W_X     = XW'(WINDOW);

      logic [SW-1:0]     acc;
      logic [DATA_W-1:0] sh;
      logic              neg;
      logic              busy;
      logic              phase;
      logic [CNT_W-1:0]  cnt;
      logic [XW-1:0]     x;
      logic [XW+31:0]    prod;
      logic [XW-1:0]     x_q;
      logic [XW-1:0]     q_q;
      logic [SW-1:0]     acc_step;
      logic [SW:0]       adj;
      logic [SW-1:0]     slot_fix;

      always_comb begin
        x        = {acc, sh[DATA_W-1 -: CHUNK]};
        prod     = (XW+32)'(x) * (XW+32)'(RECIP);
        acc_step = SW'(x_q - q_q * W_X);
        adj      = {1'b0, acc} + (neg ? (W_EXT - WRAP) : '0);
        slot_fix = (adj >= W_EXT) ? SW'(adj - W_EXT) : SW'(adj);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy  <= 1'b0;
          done  <= 1'b0;
          phase <= 1'b0;
          cnt   <= '0;
        end else begin
          done <= busy && !start && !phase && (cnt == CNT_W'(NCHUNK));
          if (start) begin
            busy  <= 1'b1;
            phase <= 1'b0;
            cnt   <= '0;
            acc   <= '0;
            sh    <= value;
            neg   <= value[DATA_W-1];
          end else if (busy) begin
            if (!phase) begin
              if (cnt == CNT_W'(NCHUNK)) begin
                busy <= 1'b0;
                slot <= slot_fix;
              end else begin
                x_q   <= x;
                q_q   <= prod[XW+31:32];
                phase <= 1'b1;
              end
            end else begin
              acc   <= acc_step;
              sh    <= {sh[DATA_W-CHUNK-1:0], {CHUNK{1'b0}}};
              cnt   <= cnt + 1'b1;
              phase <= 1'b0;
            end
          end
        end
      end
    end
  endgenerate

endmodule

### test/tb_doacross_sync_table.sv
`timescale 1ns / 100ps

module tb_doacross_sync_table;
  import dst_pkg::*;

  localparam int NUM_IDS = NUM_IDS_DEF;
  localparam int WINDOW = WINDOW_DEF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;
  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 280;

  typedef struct {
    opcode_t                  op;
    logic signed [DATA_W-1:0] iter;
    logic signed [DATA_W-1:0] distance;
    logic [ID_W-1:0]          id;
    bit                       has_exp;
    status_t                  exp;
  } dst_item_t;

  logic clk;
  logic rst;

  dst_req_if req ();
  dst_rsp_if rsp ();
  dst_cfg_if cfg ();

  doacross_sync_table #(
    .NUM_IDS(NUM_IDS),
    .WINDOW (WINDOW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  // Shadow of the completion table
  longint  done_iter [NUM_IDS*WINDOW];
  bit      slot_posted [NUM_IDS*WINDOW];
  longint  loop_start_q;

  status_t pending_status [$];
  int      errors;
  bit      burst;
  int      hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int window_slot(longint v);
    longint m;
    m = v % WINDOW;
    if (m < 0) m += WINDOW;
    return int'(m);
  endfunction

  function automatic status_t predict_status(dst_item_t it);
    longint  iter_v;
    longint  dep;
    int      idx;
    status_t st;
    iter_v = it.iter;
    st = ST_ACCEPTED;
    case (it.op)
      OP_RESTART: begin
        foreach (slot_posted[i]) slot_posted[i] = 1'b0;
      end
      OP_POST: begin
        if (it.id < NUM_IDS) begin
          idx = int'(it.id) * WINDOW + window_slot(iter_v);
          done_iter[idx] = iter_v;
          slot_posted[idx] = 1'b1;
        end else begin
          st = ST_POST_IGNORED;
        end
      end
      OP_WAIT: begin
        if (it.id >= NUM_IDS) begin
          st = ST_ID_ERROR;
        end else begin
          dep = iter_v - longint'(it.distance);
          if (dep < loop_start_q) begin
            st = ST_READY;
          end else begin
            idx = int'(it.id) * WINDOW + window_slot(dep);
            st = (slot_posted[idx] && done_iter[idx] >= dep) ? ST_READY : ST_NOT_READY;
          end
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  function automatic dst_item_t row(opcode_t op, longint iter, longint distance, int id,
                                    bit has_exp = 1'b0, status_t exp = ST_ACCEPTED);
    dst_item_t it;
    it.op = op;
    it.iter = iter;
    it.distance = distance;
    it.id = ID_W'(id);
    it.has_exp = has_exp;
    it.exp = exp;
    return it;
  endfunction

  function automatic int pick_gap();
    int k;
    if (burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns ERROR %s", $time, msg);
    errors++;
  endtask

  task automatic send_item(dst_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= it.op;
    req.iteration <= it.iter;
    req.distance <= it.distance;
    req.dep_id <= it.id;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (it.has_exp) begin
      void'(predict_status(it));
      pending_status.push_back(it.exp);
    end else begin
      pending_status.push_back(predict_status(it));
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_loop_start(longint v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    loop_start_q = v;
  endtask

  // Response side: check each transaction, then stall at random
  initial begin
    int stall_left;
    int hold_left;
    status_t exp;
    stall_left = 0;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("status %0d with nothing outstanding", rsp.status));
        end else begin
          exp = pending_status.pop_front();
          if (rsp.status !== exp)
            report_mismatch($sformatf("status got %0d want %s", rsp.status, exp.name()));
        end
        stall_left = pick_gap();
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    dst_item_t directed [N_DIRECTED];
    longint    starts [N_PHASES];
    dst_item_t it;
    longint    base;
    int        r;
    int        k;

    errors = 0;
    burst = 1'b0;
    hold_req = 0;
    loop_start_q = 0;
    foreach (slot_posted[i]) begin
      slot_posted[i] = 1'b0;
      done_iter[i] = 0;
    end
    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = OP_RESTART;
    req.iteration = '0;
    req.distance = '0;
    req.dep_id = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    directed = '{
      row(OP_WAIT, 5, 1, 0, 1'b1, ST_NOT_READY),
      row(OP_WAIT, 0, 0, NUM_IDS, 1'b1, ST_ID_ERROR),
      row(OP_WAIT, MAX64, MIN64, 16'hFFFF, 1'b1, ST_ID_ERROR),
      row(OP_POST, 7, 0, NUM_IDS, 1'b1, ST_POST_IGNORED),
      row(OP_POST, MAX64, MAX64, 16'hFFFF, 1'b1, ST_POST_IGNORED),
      row(OP_POST, 4, MIN64, 0, 1'b1, ST_ACCEPTED),
      row(OP_WAIT, 5, 1, 0),
      row(OP_WAIT, -1, 0, 0, 1'b1, ST_READY),
      row(OP_WAIT, 0, 0, NUM_IDS - 1),
      row(OP_POST, -1, 0, NUM_IDS - 1, 1'b1, ST_ACCEPTED),
      row(OP_POST, MAX64, 0, NUM_IDS - 1, 1'b1, ST_ACCEPTED),
      row(OP_WAIT, 63, 0, NUM_IDS - 1),
      row(OP_POST, 63, 0, NUM_IDS - 1, 1'b1, ST_ACCEPTED),
      row(OP_WAIT, MAX64, 0, NUM_IDS - 1),
      // dependence wraps round the 64-bit range in both directions
      row(OP_WAIT, MIN64, 1, 3),
      row(OP_WAIT, MAX64, -1, 3),
      row(OP_WAIT, 0, MIN64, 3),
      row(OP_POST, MIN64, 0, 2, 1'b1, ST_ACCEPTED),
      row(OP_WAIT, 64, 64, 2),
      row(OP_NOP, 0, 0, 0, 1'b1, ST_ACCEPTED),
      row(OP_NOP, MAX64, MIN64, 16'hFFFF, 1'b1, ST_ACCEPTED),
      row(OP_RESTART, -1, -1, 16'hFFFF, 1'b1, ST_ACCEPTED),
      row(OP_WAIT, 4, 0, 0),
      row(OP_POST, -65, 0, 1, 1'b1, ST_ACCEPTED)
    };
    starts = '{MIN64, 37, MAX64, -100, {$urandom, $urandom}, 0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      write_loop_start(starts[p]);
      // iterations straddle loop_start so both sides of the boundary are hit
      base = starts[p] - 16;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          burst = ($urandom_range(0, 3) == 0);
          if (p == 1 && n == 40) begin
            burst = 1'b1;
            hold_req = 400;
          end
        end
        it.has_exp = 1'b0;
        it.exp = ST_ACCEPTED;
        it.id = ($urandom_range(0, 19) == 0) ? ID_W'($urandom)
                                              : ID_W'($urandom_range(0, NUM_IDS - 1));
        it.iter = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                               : base + longint'($urandom_range(0, 200));
        it.distance = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 46) begin
          it.op = OP_POST;
        end else if (r < 92) begin
          it.op = OP_WAIT;
          k = $urandom_range(0, 9);
          if (k < 7) it.distance = DATA_W'($urandom_range(0, 6));
          else if (k == 7) it.distance = -longint'($urandom_range(1, 4));
          else if (k == 9) it.distance = DATA_W'($urandom_range(WINDOW - 4, WINDOW + 6));
        end else if (r < 93) begin
          it.op = OP_RESTART;
        end else if (r < 96) begin
          it.op = OP_NOP;
        end else begin
          it.op = opcode_t'($urandom_range(0, 3));
        end
        send_item(it);
      end
    end

    burst = 1'b0;
    wait_drained();
    // a stray response could trail a restart by a full clearing pass
    repeat (NUM_IDS * WINDOW + 100) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
